/* rtl/fifo_hash_collision_checker_top_assert.svh */
// Assertion macros for the hash collision cache.
// Used by the checker module bound to the top level.
`ifndef FIFO_HASH_COLLISION_CHECKER_TOP_ASSERT_SVH
`define FIFO_HASH_COLLISION_CHECKER_TOP_ASSERT_SVH

// Check a property on each rising edge, skipped while reset is held.
`define HCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hash collision cache assertion failed");

// Check a property on each rising edge, reset edges included.
`define HCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hash collision cache reset assertion failed");

`endif

/* rtl/hcc_pkg.sv */
// Shared types, codes and helper functions for the hash collision cache.
// No dependencies; imported by every module of the block.
`default_nettype none

package hcc_pkg;

  // Default number of entries and field widths
  localparam int HCC_DEPTH  = 256;
  localparam int HASH_W     = 32;
  localparam int TOK_W      = 64;
  localparam int TOK_BYTES  = 16;
  localparam int CFG_W      = 9;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 8;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // Operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HASH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXACT = 2'd2;

  // One stored entry
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [TOK_W-1:0]  tok_high;
    logic [TOK_W-1:0]  tok_low;
  } entry_t;

  // Compare unit result
  typedef struct packed {
    logic hash_hit;
    logic exact;
  } match_t;

  // Result word handed from the sequencer to the output register
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } res_t;

  // Width of the ring size value: holds the register value and DEPTH itself
  function automatic int ring_w(input int depth);
    int aw;
    aw = $clog2(depth) + 1;
    return (aw > CFG_W) ? aw : CFG_W;
  endfunction

  // Zero every byte from the first NUL byte onward
  function automatic logic [2*TOK_W-1:0] normalize_token(input logic [2*TOK_W-1:0] tok);
    logic [2*TOK_W-1:0] res;
    logic               keep;
    res  = tok;
    keep = 1'b1;
    for (int b = 0; b < TOK_BYTES; b++) begin
      if (tok[b*8 +: 8] == 8'd0) keep = 1'b0;
      if (!keep) res[b*8 +: 8] = 8'd0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/hcc_ram.sv */
// Entry memory: one write port, one registered read port.
// Depends on hcc_pkg for the entry type.
`default_nettype none

module hcc_ram
  import hcc_pkg::*;
#(
  parameter int DEPTH = HCC_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data valid next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/hcc_match.sv */
// Compare unit: checks one stored entry against the search key.
// Depends on hcc_pkg for the entry and match types.
`default_nettype none

module hcc_match
  import hcc_pkg::*;
(
  input  wire entry_t              ent,
  input  wire logic [HASH_W-1:0]   key_hash,
  input  wire logic [2*TOK_W-1:0]  key_tok,
  output match_t                   m
);

  // Hash hit on a live entry, exact when the token agrees too
  always_comb begin
    m.hash_hit = ent.valid && (ent.hash == key_hash);
    m.exact    = m.hash_hit && ({ent.tok_high, ent.tok_low} == key_tok);
  end

endmodule

`default_nettype wire

/* rtl/hcc_seq.sv */
// Sequencer: clears the memory after reset, then scans all entries per word
// through the shared compare unit and, on an add, updates the ring. Depends on hcc_pkg.
`default_nettype none

module hcc_seq
  import hcc_pkg::*;
#(
  parameter int DEPTH = HCC_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int RW = ring_w(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input word
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_operation,
  input  wire logic [HASH_W-1:0] in_hash,
  input  wire logic [TOK_W-1:0]  in_token_low,
  input  wire logic [TOK_W-1:0]  in_token_high,
  // effective ring size
  input  wire logic [RW-1:0]     ring_size,
  // result toward the output register
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res,
  // memory port
  output logic                   ram_wr_en,
  output logic [AW-1:0]          ram_wr_addr,
  output entry_t                 ram_wr_data,
  output logic                   ram_rd_en,
  output logic [AW-1:0]          ram_rd_addr,
  // compare unit
  output logic [HASH_W-1:0]      key_hash,
  output logic [2*TOK_W-1:0]     key_tok,
  input  wire match_t            m
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  localparam logic [AW:0] IDX_END = (AW+1)'(DEPTH);

  state_t              state_r, state_nxt;
  logic [AW:0]         idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pend_idx_r, pend_idx_nxt;
  logic                op_r, op_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [2*TOK_W-1:0]  tok_r, tok_nxt;
  logic [AW-1:0]       w_r, w_nxt;
  logic [AW-1:0]       next_slot_r, next_slot_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic                found_r, found_nxt;
  logic                consider;
  logic [RW-1:0]       w_inc;

  assign key_hash = hash_r;
  assign key_tok  = tok_r;
  assign in_stall = (state_r != S_IDLE);
  assign w_inc    = RW'(w_r) + RW'(1);

  // Skip the slot being replaced on add; stop at the first exact hit on find
  assign consider = pend_r &&
                    ((op_r == OP_FIND) ? !found_r : (pend_idx_r != w_r));

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = idx_r[AW-1:0];
    op_nxt        = op_r;
    hash_nxt      = hash_r;
    tok_nxt       = tok_r;
    w_nxt         = w_r;
    next_slot_nxt = next_slot_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_r[AW-1:0];
    ram_wr_data   = '0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_r[AW-1:0];
    res_valid     = 1'b0;
    res.status    = status_r;
    res.slot      = (op_r == OP_ADD) ? SLOT_W'(w_r) : SLOT_W'(slot_r);

    case (state_r)
      // Sweep the memory, marking every entry invalid
      S_CLEAR: begin
        ram_wr_en = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == IDX_END - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a word, latch the key and pick the write slot
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          hash_nxt   = in_hash;
          tok_nxt    = normalize_token({in_token_high, in_token_low});
          w_nxt      = (RW'(next_slot_r) < ring_size) ? next_slot_r : '0;
          idx_nxt    = '0;
          status_nxt = ST_NONE;
          slot_nxt   = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      // Issue one read per cycle, compare the entry read last cycle
      S_SCAN: begin
        if (idx_r != IDX_END) begin
          ram_rd_en    = 1'b1;
          pend_nxt     = 1'b1;
          idx_nxt      = idx_r + 1'b1;
        end
        if (consider && m.exact) begin
          status_nxt = ST_EXACT;
          if (op_r == OP_ADD) begin
            // drop the older duplicate
            ram_wr_en   = 1'b1;
            ram_wr_addr = pend_idx_r;
          end else begin
            slot_nxt  = pend_idx_r;
            found_nxt = 1'b1;
          end
        end else if (consider && m.hash_hit && (status_r == ST_NONE)) begin
          status_nxt = ST_HASH;
        end
        if ((idx_r == IDX_END) && !pend_r) begin
          if (op_r == OP_ADD) begin
            // store the new entry and advance the ring
            ram_wr_en            = 1'b1;
            ram_wr_addr          = w_r;
            ram_wr_data.valid    = 1'b1;
            ram_wr_data.hash     = hash_r;
            ram_wr_data.tok_high = tok_r[2*TOK_W-1:TOK_W];
            ram_wr_data.tok_low  = tok_r[TOK_W-1:0];
            next_slot_nxt        = (w_inc < ring_size) ? w_inc[AW-1:0] : '0;
          end
          state_nxt = S_DONE;
        end
      end

      // Hand the result over once the output register is free
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      next_slot_r <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      next_slot_r <= next_slot_nxt;
    end
  end

  // Key and scan bookkeeping
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    op_r       <= op_nxt;
    hash_r     <= hash_nxt;
    tok_r      <= tok_nxt;
    w_r        <= w_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    found_r    <= found_nxt;
  end

endmodule

`default_nettype wire

/* rtl/fifo_hash_collision_checker_top.sv */
// Top level of the hash collision cache: config register, output register,
// entry memory, compare unit and sequencer. Depends on hcc_pkg.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  in_operation, in_hash, in_token_low,
//                                            in_token_high
//   out      source     out_valid / out_stall out_status, out_slot
//   cfg      sink       cfg_wr_en            cfg_wr_data (entries_in_use)
//
// Every entry is read in turn for each word through the single read port of the
// entry memory and checked by one compare unit. After reset the block sweeps
// the memory invalid with in_stall high. A stalled result waits in the output
// register while the next word is already being scanned; the scan holds at its
// end until the output register is free.
`default_nettype none

module fifo_hash_collision_checker_top
  import hcc_pkg::*;
#(
  parameter int DEPTH = HCC_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_operation,
  input  wire logic [HASH_W-1:0]   in_hash,
  input  wire logic [TOK_W-1:0]    in_token_low,
  input  wire logic [TOK_W-1:0]    in_token_high,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_W-1:0]        out_slot,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_W-1:0]    cfg_wr_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int RW = ring_w(DEPTH);

  logic [CFG_W-1:0]    cfg_r;
  logic [RW-1:0]       cfg_ext;
  logic [RW-1:0]       ring_size;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                res_valid;
  logic                res_ready;
  res_t                res;
  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  entry_t              ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  entry_t              ram_rd_data;
  logic [HASH_W-1:0]   key_hash;
  logic [2*TOK_W-1:0]  key_tok;
  match_t              m;

  // Hold the ring size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Clamp the ring size to 1 .. DEPTH
  assign cfg_ext   = RW'(cfg_r);
  assign ring_size = (cfg_ext == '0)          ? RW'(1) :
                     (cfg_ext > RW'(DEPTH))   ? RW'(DEPTH) : cfg_ext;

  // Output register
  assign res_ready     = !out_valid_r || !out_stall;
  assign out_valid_nxt = (res_valid && res_ready) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res.status;
      out_slot_r   <= res.slot;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  hcc_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  hcc_match u_match (
    .ent      (ram_rd_data),
    .key_hash (key_hash),
    .key_tok  (key_tok),
    .m        (m)
  );

  hcc_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_hash       (in_hash),
    .in_token_low  (in_token_low),
    .in_token_high (in_token_high),
    .ring_size     (ring_size),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr   (ram_rd_addr),
    .key_hash      (key_hash),
    .key_tok       (key_tok),
    .m             (m)
  );

endmodule

`default_nettype wire

/* rtl/hcc_checker.sv */
// Port-level assertions for the hash collision cache, bound to the top level.
// Depends on hcc_pkg and the assertion macro header.
`default_nettype none
`include "fifo_hash_collision_checker_top_assert.svh"

module hcc_checker
  import hcc_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [SLOT_W-1:0]   out_slot
);

  // Reset leaves the block busy clearing and with no result pending
  `HCC_ASSERT_ALWAYS(a_reset_busy, clk, !rst_n |=> (in_stall && !out_valid))

  // An accepted word keeps the input side stalled while it is scanned
  `HCC_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)

  // A shown result carries one of the three status codes
  `HCC_ASSERT(a_status_code, clk, rst_n, out_valid |-> (out_status == ST_NONE || out_status == ST_HASH || out_status == ST_EXACT))

  // A stalled result holds
  `HCC_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_status) && $stable(out_slot)))

endmodule

bind fifo_hash_collision_checker_top hcc_checker u_hcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_slot   (out_slot)
);

`default_nettype wire
